// ===== rtl/core/htub_pkg.sv =====
// ----------------------------------------------------------------------------
// htub_pkg
// Shared types and constants for the head tile upscale and blend block.
// ----------------------------------------------------------------------------
package htub_pkg;

	// tile store geometry
	localparam int MAX_HEAD_SIZE = 64;
	localparam int OUT_SIZE      = 64;
	localparam int TILE_AW       = $clog2(MAX_HEAD_SIZE * MAX_HEAD_SIZE);
	localparam int COORD_W       = $clog2(MAX_HEAD_SIZE);
	localparam int HEAD_W        = $clog2(MAX_HEAD_SIZE) + 1;
	localparam int COL_W         = $clog2(OUT_SIZE);
	localparam int SCALE_W       = COL_W + HEAD_W;

	// configuration port
	localparam int CFG_W         = 13;
	localparam int MIN_WIDTH     = 64;

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} htub_cfg_idx_t;

	// request codes
	typedef enum logic [0:0] {
		REQ_LOAD = 1'b0,
		REQ_ROW  = 1'b1
	} htub_req_t;

	// result status codes
	typedef enum logic [0:0] {
		STAT_OK     = 1'b0,
		STAT_REJECT = 1'b1
	} htub_status_t;

	// row sequencer
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SETUP = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_DRAIN = 4'b1000
	} htub_state_t;

	// stored pixels
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} htub_face_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} htub_hat_t;

endpackage

// ===== rtl/core/head_tile_upscale_blend_unit.sv =====
// ----------------------------------------------------------------------------
// head_tile_upscale_blend_unit
// Keeps the face and hat tiles of a skin image and emits a 64x64 head,
// one row per request, nearest-neighbour scaled and alpha-blended.
// ----------------------------------------------------------------------------
// A load (req_type 0) is written into the tile store at the accept edge and
// busy stays low, so loads can be issued every cycle. A row request with a
// valid layout raises busy through one setup state that scales the
// row index, a run state in which the shared scaling multiplier produces one
// tile address per column, and one drain state; the 64 results come one per
// cycle through the tile read register and the blend output register. A row
// request with an invalid layout gives one reject result in the next cycle
// and does not raise busy.
// Results are shown for a single cycle on result_valid and cannot be stalled.
// ----------------------------------------------------------------------------
module head_tile_upscale_blend_unit
	import htub_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	// command
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [11:0]        pixel_x,
	input  logic [11:0]        pixel_y,
	input  logic [7:0]         pixel_red,
	input  logic [7:0]         pixel_green,
	input  logic [7:0]         pixel_blue,
	input  logic [7:0]         pixel_alpha,
	input  logic [COL_W-1:0]   row_index,
	// results
	output logic               result_valid,
	output logic [COL_W-1:0]   out_column,
	output logic [7:0]         out_red,
	output logic [7:0]         out_green,
	output logic [7:0]         out_blue,
	output logic [7:0]         out_opacity,
	output logic               status,
	output logic               last_of_row
);

	// configuration registers
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(64);
			height_q <= CFG_W'(64);
		end else if (cfg_we) begin
			case (htub_cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				CFG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// layout check
	logic [CFG_W-4:0]  head_full;
	logic [CFG_W-1:0]  head_x6;
	logic [CFG_W-1:0]  head_x2;
	logic              layout_ok;
	logic [HEAD_W-1:0] head;

	assign head_full = width_q[CFG_W-1:3];
	assign head_x6   = {head_full, 3'b000} - {2'b00, head_full, 1'b0};
	assign head_x2   = {2'b00, head_full, 1'b0};
	assign layout_ok = (width_q >= CFG_W'(MIN_WIDTH)) && (width_q[2:0] == 3'd0)
		&& (head_x6 <= width_q) && (head_x2 <= height_q)
		&& (head_full <= (CFG_W-3)'(MAX_HEAD_SIZE));
	assign head      = head_full[HEAD_W-1:0];

	// load decode: tile bounds in source coordinates
	logic [11:0] h1, h2, h5, h6;
	logic        in_rows, in_face, in_hat;
	logic [11:0] ry, rx_face, rx_hat;

	assign h1      = 12'(head);
	assign h2      = {h1[10:0], 1'b0};
	assign h5      = {h1[9:0], 2'b00} + h1;
	assign h6      = h5 + h1;
	assign in_rows = (pixel_y >= h1) && (pixel_y < h2);
	assign in_face = in_rows && (pixel_x >= h1) && (pixel_x < h2);
	assign in_hat  = in_rows && (pixel_x >= h5) && (pixel_x < h6);
	assign ry      = pixel_y - h1;
	assign rx_face = pixel_x - h1;
	assign rx_hat  = pixel_x - h5;

	logic accept, load_go, row_go, reject_go;

	assign accept    = start && !busy;
	assign load_go   = accept && (req_type == REQ_LOAD) && layout_ok;
	assign row_go    = accept && (req_type == REQ_ROW) && layout_ok;
	assign reject_go = accept && (req_type == REQ_ROW) && !layout_ok;

	// row sequencer
	htub_state_t         state_q;
	logic [COL_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [COORD_W-1:0]  sy_q;

	assign busy = (state_q != ST_IDLE);

	// shared scaling multiplier: row in setup, column while running
	logic [COL_W-1:0]   scale_op;
	logic [SCALE_W-1:0] scale_prod;
	logic [COORD_W-1:0] scaled;

	assign scale_op   = (state_q == ST_SETUP) ? row_q : col_q;
	assign scale_prod = SCALE_W'(scale_op * head);
	assign scaled     = scale_prod[COL_W+COORD_W-1:COL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (row_go) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					col_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					col_q <= col_q + COL_W'(1);
					if (col_q == COL_W'(OUT_SIZE - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// row number and scaled source row
	always_ff @(posedge clk) begin
		if (row_go) begin
			row_q <= row_index;
		end
		if (state_q == ST_SETUP) begin
			sy_q <= scaled;
		end
	end

	// tile stores
	htub_face_t face_mem [MAX_HEAD_SIZE*MAX_HEAD_SIZE];
	htub_hat_t  hat_mem  [MAX_HEAD_SIZE*MAX_HEAD_SIZE];

	logic [TILE_AW-1:0] wr_addr_face, wr_addr_hat, rd_addr;

	assign wr_addr_face = {ry[COORD_W-1:0], rx_face[COORD_W-1:0]};
	assign wr_addr_hat  = {ry[COORD_W-1:0], rx_hat[COORD_W-1:0]};
	assign rd_addr      = {sy_q, scaled};

	always_ff @(posedge clk) begin
		if (load_go && in_face) begin
			face_mem[wr_addr_face] <= '{red: pixel_red, green: pixel_green,
				blue: pixel_blue};
		end
	end

	always_ff @(posedge clk) begin
		if (load_go && !in_face && in_hat) begin
			hat_mem[wr_addr_hat] <= '{red: pixel_red, green: pixel_green,
				blue: pixel_blue, alpha: pixel_alpha};
		end
	end

	// stage 1: registered tile reads
	htub_face_t       face_s1;
	htub_hat_t        hat_s1;
	logic [COL_W-1:0] col_s1;
	logic             valid_s1;

	always_ff @(posedge clk) begin
		face_s1 <= face_mem[rd_addr];
		hat_s1  <= hat_mem[rd_addr];
		col_s1  <= col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_RUN);
		end
	end

	// blend unit
	logic [7:0] bl_red, bl_green, bl_blue;

	htub_blend u_blend (
		.hat_pix  (hat_s1),
		.face_pix (face_s1),
		.red      (bl_red),
		.green    (bl_green),
		.blue     (bl_blue)
	);

	// stage 2: result register
	logic             valid_s2;
	logic [COL_W-1:0] col_s2;
	logic [7:0]       red_s2, green_s2, blue_s2, opacity_s2;
	logic             status_s2, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 || reject_go;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			col_s2     <= col_s1;
			red_s2     <= bl_red;
			green_s2   <= bl_green;
			blue_s2    <= bl_blue;
			opacity_s2 <= 8'd255;
			status_s2  <= STAT_OK;
			last_s2    <= (col_s1 == COL_W'(OUT_SIZE - 1));
		end else if (reject_go) begin
			col_s2     <= '0;
			red_s2     <= '0;
			green_s2   <= '0;
			blue_s2    <= '0;
			opacity_s2 <= '0;
			status_s2  <= STAT_REJECT;
			last_s2    <= 1'b1;
		end
	end

	assign result_valid = valid_s2;
	assign out_column   = col_s2;
	assign out_red      = red_s2;
	assign out_green    = green_s2;
	assign out_blue     = blue_s2;
	assign out_opacity  = opacity_s2;
	assign status       = status_s2;
	assign last_of_row  = last_s2;

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("row sequencer state not one-hot");

	a_no_result_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP) |-> !result_valid)
		else $error("result strobe during row setup");

	a_reject_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == STAT_REJECT) |-> last_of_row)
		else $error("reject result not marked last");

	a_run_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && col_q == COL_W'(OUT_SIZE - 1)) |=> (state_q == ST_DRAIN))
		else $error("row issue did not end after the last column");

	a_pixel_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == STAT_OK) |-> $past(valid_s1))
		else $error("pixel result without a tile read");

endmodule

// ===== rtl/core/htub_blend.sv =====
// ----------------------------------------------------------------------------
// htub_blend
// Alpha-over blend of one hat pixel onto one face pixel, three channels,
// each (hat*a + face*(255-a)) / 255 truncated.
// ----------------------------------------------------------------------------
module htub_blend
	import htub_pkg::*;
(
	input  htub_hat_t  hat_pix,
	input  htub_face_t face_pix,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	logic [7:0]  hat_c  [3];
	logic [7:0]  face_c [3];
	logic [7:0]  res_c  [3];
	logic [7:0]  inv_a;

	assign inv_a     = 8'd255 - hat_pix.alpha;
	assign hat_c[0]  = hat_pix.red;
	assign hat_c[1]  = hat_pix.green;
	assign hat_c[2]  = hat_pix.blue;
	assign face_c[0] = face_pix.red;
	assign face_c[1] = face_pix.green;
	assign face_c[2] = face_pix.blue;

	// per channel: weighted sum, then exact divide by 255 for 16-bit sums
	always_comb begin
		logic [15:0] sum;
		logic [16:0] adj;
		for (int c = 0; c < 3; c++) begin
			sum      = 16'(hat_c[c] * hat_pix.alpha) + 16'(face_c[c] * inv_a);
			adj      = {1'b0, sum} + {9'd0, sum[15:8]} + 17'd1;
			res_c[c] = adj[15:8];
		end
	end

	assign red   = res_c[0];
	assign green = res_c[1];
	assign blue  = res_c[2];

endmodule

// ===== tb/htub_checker.sv =====
// ----------------------------------------------------------------------------
// htub_checker
// Monitors the command, configuration and result ports of the head tile
// upscale and blend unit. It keeps its own copy of the layout registers and of
// both tile stores, predicts the pixels that every accepted command produces,
// and compares each result pixel with the oldest expected pixel.
// ----------------------------------------------------------------------------
module htub_checker
	import htub_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               start,
	input  logic               busy,
	input  logic               req_type,
	input  logic [11:0]        pixel_x,
	input  logic [11:0]        pixel_y,
	input  logic [7:0]         pixel_red,
	input  logic [7:0]         pixel_green,
	input  logic [7:0]         pixel_blue,
	input  logic [7:0]         pixel_alpha,
	input  logic [COL_W-1:0]   row_index,
	input  logic               result_valid,
	input  logic [COL_W-1:0]   out_column,
	input  logic [7:0]         out_red,
	input  logic [7:0]         out_green,
	input  logic [7:0]         out_blue,
	input  logic [7:0]         out_opacity,
	input  logic               status,
	input  logic               last_of_row,
	output int                 pending,
	output int                 errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TILE_DEPTH = MAX_HEAD_SIZE * MAX_HEAD_SIZE;
	localparam int CHAN_MAX   = 255;

	typedef struct {
		logic [COL_W-1:0] column;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       opacity;
		htub_status_t     status;
		logic             last;
	} row_pix_t;

	row_pix_t         row_pix_q [$];
	htub_face_t       face_mem [TILE_DEPTH];
	htub_hat_t        hat_mem [TILE_DEPTH];
	logic [CFG_W-1:0] width_r;
	logic [CFG_W-1:0] height_r;
	int               err_cnt = 0;

	assign errors = err_cnt;

	// layout validation; also returns the head size
	function automatic bit layout_good(output int hd);
		int w;
		int h;
		w = int'(width_r);
		h = int'(height_r);
		hd = w / 8;
		return (w >= MIN_WIDTH) && (w % 8 == 0) && (hd * 6 <= w) && (hd * 2 <= h) &&
			(hd <= MAX_HEAD_SIZE);
	endfunction

	// alpha-over of one color channel, truncated
	function automatic logic [7:0] blend_chan(int hat_c, int face_c, int al);
		return 8'((hat_c * al + face_c * (CHAN_MAX - al)) / CHAN_MAX);
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			err_cnt++;
		end
	endfunction

	// compare one result pixel with the oldest expectation
	task automatic match_result();
		row_pix_t e;
		if (row_pix_q.size() == 0) begin
			$error("result with nothing expected: column %0d status %0d", out_column, status);
			err_cnt++;
		end else begin
			e = row_pix_q.pop_front();
			check_field("out_column", e.column, out_column);
			check_field("out_red", e.red, out_red);
			check_field("out_green", e.green, out_green);
			check_field("out_blue", e.blue, out_blue);
			check_field("out_opacity", e.opacity, out_opacity);
			check_field("status", e.status, status);
			check_field("last_of_row", e.last, last_of_row);
		end
	endtask

	// update the tile stores or queue the pixels of one accepted command
	task automatic predict_item();
		int       hd;
		int       px;
		int       py;
		int       sy;
		int       sx;
		int       idx;
		bit       ok;
		row_pix_t e;
		ok = layout_good(hd);
		px = int'(pixel_x);
		py = int'(pixel_y);
		if (req_type == REQ_LOAD) begin
			// loads outside both tiles or with a bad layout are dropped
			if (ok && py >= hd && py < 2 * hd) begin
				if (px >= hd && px < 2 * hd)
					face_mem[(py - hd) * MAX_HEAD_SIZE + px - hd] =
						{pixel_red, pixel_green, pixel_blue};
				else if (px >= 5 * hd && px < 6 * hd)
					hat_mem[(py - hd) * MAX_HEAD_SIZE + px - 5 * hd] =
						{pixel_red, pixel_green, pixel_blue, pixel_alpha};
			end
		end else if (!ok) begin
			// rejected layout: a single zero pixel closes the row
			e.column  = '0;
			e.red     = '0;
			e.green   = '0;
			e.blue    = '0;
			e.opacity = '0;
			e.status  = STAT_REJECT;
			e.last    = 1'b1;
			row_pix_q.push_back(e);
		end else begin
			sy = int'(row_index) * hd / OUT_SIZE;
			for (int x = 0; x < OUT_SIZE; x++) begin
				sx = x * hd / OUT_SIZE;
				idx = sy * MAX_HEAD_SIZE + sx;
				e.column  = COL_W'(x);
				e.red     = blend_chan(hat_mem[idx].red, face_mem[idx].red, hat_mem[idx].alpha);
				e.green   = blend_chan(hat_mem[idx].green, face_mem[idx].green,
					hat_mem[idx].alpha);
				e.blue    = blend_chan(hat_mem[idx].blue, face_mem[idx].blue, hat_mem[idx].alpha);
				e.opacity = 8'(CHAN_MAX);
				e.status  = STAT_OK;
				e.last    = (x == OUT_SIZE - 1);
				row_pix_q.push_back(e);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < TILE_DEPTH; i++) begin
			face_mem[i] = '0;
			hat_mem[i]  = '0;
		end
	end

	// results are checked before the same edge's command is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_r  = CFG_W'(MIN_WIDTH);
			height_r = CFG_W'(MIN_WIDTH);
			row_pix_q.delete();
			pending <= 0;
		end else begin
			if (result_valid)
				match_result();
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width_r  = cfg_wdata;
					CFG_IMAGE_HEIGHT: height_r = cfg_wdata;
					default: ;
				endcase
			end
			if (start && !busy)
				predict_item();
			pending <= row_pix_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the head tile upscale and blend unit. Directed loads, row
// requests and bad layouts come first, then random phases over a range of
// layouts. Row requests only ever read tile entries that were loaded. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import htub_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TILE_DEPTH  = MAX_HEAD_SIZE * MAX_HEAD_SIZE;
	localparam int RAND_ITEMS  = 260;
	localparam int NUM_LAYOUTS = 10;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [0:0]       cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic             start;
	logic             busy;
	logic             req_type;
	logic [11:0]      pixel_x;
	logic [11:0]      pixel_y;
	logic [7:0]       pixel_red;
	logic [7:0]       pixel_green;
	logic [7:0]       pixel_blue;
	logic [7:0]       pixel_alpha;
	logic [COL_W-1:0] row_index;
	logic             result_valid;
	logic [COL_W-1:0] out_column;
	logic [7:0]       out_red;
	logic [7:0]       out_green;
	logic [7:0]       out_blue;
	logic [7:0]       out_opacity;
	logic             status;
	logic             last_of_row;
	int               pending;
	int               errors;

	// stimulus bookkeeping: current layout and which tile entries hold data
	int cur_w = MIN_WIDTH;
	int cur_h = MIN_WIDTH;
	bit face_wr [TILE_DEPTH];
	bit hat_wr [TILE_DEPTH];
	bit no_idle = 0;
	int counted = 0;

	// random phases: small heads mostly, bad layouts in between
	int layout_w [NUM_LAYOUTS] = '{64, 128, 96, 200, 64, 60, 256, 130, 72, 512};
	int layout_h [NUM_LAYOUTS] = '{64, 32, 24, 4096, 16, 64, 64, 4096, 18, 128};

	head_tile_upscale_blend_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_red    (pixel_red),
		.pixel_green  (pixel_green),
		.pixel_blue   (pixel_blue),
		.pixel_alpha  (pixel_alpha),
		.row_index    (row_index),
		.result_valid (result_valid),
		.out_column   (out_column),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_opacity  (out_opacity),
		.status       (status),
		.last_of_row  (last_of_row)
	);

	htub_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_red    (pixel_red),
		.pixel_green  (pixel_green),
		.pixel_blue   (pixel_blue),
		.pixel_alpha  (pixel_alpha),
		.row_index    (row_index),
		.result_valid (result_valid),
		.out_column   (out_column),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_opacity  (out_opacity),
		.status       (status),
		.last_of_row  (last_of_row),
		.pending      (pending),
		.errors       (errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic bit layout_now(output int hd);
		hd = cur_w / 8;
		return (cur_w >= MIN_WIDTH) && (cur_w % 8 == 0) && (hd * 6 <= cur_w) &&
			(hd * 2 <= cur_h) && (hd <= MAX_HEAD_SIZE);
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_len();
		int p;
		if (no_idle)
			return 0;
		p = $urandom_range(99);
		if (p < 60)
			return 0;
		else if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int rand_alpha();
		int p;
		p = $urandom_range(3);
		if (p == 0)
			return 0;
		else if (p == 1)
			return 255;
		return $urandom_range(255);
	endfunction

	// one command transfer, then an optional gap
	task automatic issue(htub_req_t kind, int x, int y, int r, int g, int b, int a, int row);
		int gap;
		counted++;
		start       <= 1'b1;
		req_type    <= kind;
		pixel_x     <= 12'(x);
		pixel_y     <= 12'(y);
		pixel_red   <= 8'(r);
		pixel_green <= 8'(g);
		pixel_blue  <= 8'(b);
		pixel_alpha <= 8'(a);
		row_index   <= COL_W'(row);
		do
			@(posedge clk);
		while (busy);
		gap = idle_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// source pixel load; marks the tile entry it fills
	task automatic load_px(int x, int y, int r, int g, int b, int a);
		int hd;
		if (layout_now(hd) && y >= hd && y < 2 * hd) begin
			if (x >= hd && x < 2 * hd) begin
				face_wr[(y - hd) * MAX_HEAD_SIZE + x - hd] = 1'b1;
			end else if (x >= 5 * hd && x < 6 * hd) begin
				hat_wr[(y - hd) * MAX_HEAD_SIZE + x - 5 * hd] = 1'b1;
			end
		end
		issue(REQ_LOAD, x, y, r, g, b, a, $urandom_range(OUT_SIZE - 1));
	endtask

	// row request; first loads any sampled tile entry still empty
	task automatic row_req(int row);
		int hd;
		int sy;
		if (layout_now(hd)) begin
			sy = row * hd / OUT_SIZE;
			for (int sx = 0; sx < hd; sx++) begin
				if (!face_wr[sy * MAX_HEAD_SIZE + sx])
					load_px(hd + sx, hd + sy, $urandom_range(255), $urandom_range(255),
						$urandom_range(255), rand_alpha());
				if (!hat_wr[sy * MAX_HEAD_SIZE + sx])
					load_px(5 * hd + sx, hd + sy, $urandom_range(255), $urandom_range(255),
						$urandom_range(255), rand_alpha());
			end
		end
		issue(REQ_ROW, $urandom_range(4095), $urandom_range(4095), $urandom_range(255),
			$urandom_range(255), $urandom_range(255), $urandom_range(255), row);
	endtask

	// wait until every expected pixel is out and the sequencer is idle
	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_layout(int w, int h);
		quiesce();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_wdata <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_wdata <= CFG_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_w = w;
		cur_h = h;
		@(posedge clk);
	endtask

	task automatic rand_item();
		int hd;
		int p;
		int sx;
		int sy;
		p = $urandom_range(99);
		if (layout_now(hd)) begin
			if (p < 55) begin
				sx = $urandom_range(hd - 1);
				sy = $urandom_range(hd - 1);
				load_px(($urandom_range(1) ? hd : 5 * hd) + sx, hd + sy, $urandom_range(255),
					$urandom_range(255), $urandom_range(255), rand_alpha());
			end else if (p < 70) begin
				load_px($urandom_range(4095), $urandom_range(4095), $urandom_range(255),
					$urandom_range(255), $urandom_range(255), $urandom_range(255));
			end else begin
				row_req($urandom_range(OUT_SIZE - 1));
			end
		end else if (p < 50) begin
			row_req($urandom_range(OUT_SIZE - 1));
		end else begin
			load_px($urandom_range(4095), $urandom_range(4095), $urandom_range(255),
				$urandom_range(255), $urandom_range(255), $urandom_range(255));
		end
	endtask

	initial begin
		int target;
		int phase;
		int hd;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_IMAGE_WIDTH;
		cfg_wdata   = '0;
		start       = 1'b0;
		req_type    = REQ_LOAD;
		pixel_x     = '0;
		pixel_y     = '0;
		pixel_red   = '0;
		pixel_green = '0;
		pixel_blue  = '0;
		pixel_alpha = '0;
		row_index   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset layout 64x64: tile corners, extreme colors and alphas, near misses
		load_px(8, 8, 0, 0, 0, 255);
		load_px(15, 15, 255, 255, 255, 0);
		load_px(40, 8, 255, 255, 255, 0);
		load_px(47, 15, 0, 0, 0, 255);
		load_px(40, 15, 255, 0, 128, 128);
		load_px(0, 0, 255, 255, 255, 255);
		load_px(4095, 4095, 255, 255, 255, 255);
		load_px(16, 8, 1, 2, 3, 4);
		load_px(48, 8, 1, 2, 3, 4);
		load_px(8, 7, 1, 2, 3, 4);
		load_px(39, 16, 1, 2, 3, 4);
		row_req(0);
		row_req(OUT_SIZE - 1);

		// rejected layouts: too narrow, not a multiple of 8, too short,
		// head too large, and the extreme sizes 4096, 4095 and 1
		set_layout(63, 64);
		row_req(0);
		load_px(9, 9, 7, 7, 7, 7);
		set_layout(100, 64);
		row_req(5);
		set_layout(128, 31);
		row_req(OUT_SIZE - 1);
		set_layout(520, 4096);
		row_req(1);
		set_layout(4096, 4096);
		row_req(2);
		set_layout(4095, 4095);
		row_req(3);
		set_layout(1, 1);
		row_req(4);
		load_px(0, 0, 9, 9, 9, 9);

		// largest head, then a load at the right image edge outside both tiles
		set_layout(512, 128);
		row_req(OUT_SIZE - 1);
		load_px(511, 64, 200, 100, 50, 25);

		// random phases until the item budget is used up
		phase = 0;
		while (counted < RAND_ITEMS) begin
			set_layout(layout_w[phase % NUM_LAYOUTS], layout_h[phase % NUM_LAYOUTS]);
			no_idle = ($urandom_range(3) == 0);
			target = counted + (layout_now(hd) ? 30 : 12);
			while (counted < target)
				rand_item();
			phase++;
		end
		no_idle = 0;

		quiesce();
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/htub_pkg.sv
rtl/core/htub_blend.sv
rtl/core/head_tile_upscale_blend_unit.sv
tb/htub_checker.sv
tb/tb_top.sv
